@@ hw/rtl/sma_pkg.sv @@
// shared constants and codes for the stack machine alu
package sma_pkg;

  localparam int DATA_W        = 32;
  localparam int OPC_W         = 4;
  localparam int STAT_W        = 2;
  localparam int STACK_DEPTH_D = 256;
  localparam int CNT_W         = $clog2(DATA_W);

  localparam logic [OPC_W-1:0] OP_CONST = 4'd0;
  localparam logic [OPC_W-1:0] OP_ADD   = 4'd1;
  localparam logic [OPC_W-1:0] OP_SUB   = 4'd2;
  localparam logic [OPC_W-1:0] OP_MUL   = 4'd3;
  localparam logic [OPC_W-1:0] OP_DIV   = 4'd4;
  localparam logic [OPC_W-1:0] OP_MAX   = 4'd5;
  localparam logic [OPC_W-1:0] OP_MIN   = 4'd6;
  localparam logic [OPC_W-1:0] OP_NEG   = 4'd7;
  localparam logic [OPC_W-1:0] OP_DUP   = 4'd8;
  localparam logic [OPC_W-1:0] OP_SWAP  = 4'd9;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_UNDER = 2'd1;
  localparam logic [STAT_W-1:0] ST_OVER  = 2'd2;
  localparam logic [STAT_W-1:0] ST_DIV0  = 2'd3;

endpackage

@@ hw/rtl/stack_machine_alu.sv @@
// stack machine alu: operand stack with a shared adder for all arithmetic
//
// A request is taken on a rising edge where start is high and busy is low:
// opcode selects the instruction and operand_value is the value that CONST
// pushes. busy stays high until the request has finished. The result (new top
// of stack, depth and status) is shown for exactly one cycle with done high;
// the receiver cannot hold it off and must take it in that cycle.
// Steps from the accepting edge to the done cycle:
//   CONST, DUP, NEG, SWAP, ADD, SUB, MAX, MIN and all errors: decode only
//   MUL: decode, then shift-and-add, one multiplier bit per cycle
//   DIV: decode, then sign fix-up plus restoring division, one quotient bit
//   per cycle
// Both long operations are paced by the single 33-bit adder. A new request
// may be accepted in the done cycle of the previous one.
// The top entry lives in a register; the rest sit in a single-port-write
// memory whose read is registered. Reset empties the stack at once, with no
// clearing pass, and entries are only read after being written.
module stack_machine_alu #(
  parameter int STACK_DEPTH = sma_pkg::STACK_DEPTH_D
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [sma_pkg::OPC_W-1:0]              opcode,
  input  logic signed [sma_pkg::DATA_W-1:0]      operand_value,
  output logic                                   done,
  output logic signed [sma_pkg::DATA_W-1:0]      top_value,
  output logic [$clog2(STACK_DEPTH+1)-1:0]       stack_depth,
  output logic [sma_pkg::STAT_W-1:0]             status
);

  localparam int DW  = sma_pkg::DATA_W;
  localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SPW = $clog2(STACK_DEPTH+1);
  localparam int CW  = sma_pkg::CNT_W;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_ABSA, S_ABSB, S_DIVS, S_FIX, S_MULS
  } state_t;

  state_t                     state;
  logic [sma_pkg::OPC_W-1:0]  opr;
  logic [DW-1:0]              xval;
  logic [DW-1:0]              top;
  logic [DW-1:0]              xa;
  logic [DW-1:0]              xb;
  logic [DW-1:0]              acc;
  logic [DW-1:0]              qr;
  logic [CW-1:0]              cnt;
  logic                       negq;
  logic [SPW-1:0]             sp;
  logic [sma_pkg::STAT_W-1:0] stat;

  logic [DW-1:0] mem [STACK_DEPTH];
  logic [DW-1:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;

  logic [SPW-1:0]             sp_m1;
  logic [SPW-1:0]             sp_m2;
  logic [1:0]                 need;
  logic                       under;
  logic                       over;
  logic                       lt;
  logic [sma_pkg::STAT_W-1:0] dec_stat;
  logic                       dec_run;

  logic [DW:0]   add_x;
  logic [DW:0]   add_y;
  logic          add_sub;
  logic [DW+1:0] sum;

  assign sp_m1   = sp - SPW'(1);
  assign sp_m2   = sp - SPW'(2);
  assign rd_addr = sp_m2[AW-1:0];

  // need and error checks
  always_comb begin
    case (opr)
      sma_pkg::OP_CONST: need = 2'd0;
      sma_pkg::OP_NEG, sma_pkg::OP_DUP: need = 2'd1;
      default: need = 2'd2;
    endcase
    under = (sp < SPW'(need));
    over  = ((opr == sma_pkg::OP_CONST) || (opr == sma_pkg::OP_DUP)) &&
            (sp == SPW'(STACK_DEPTH));
    dec_stat = sma_pkg::ST_OK;
    dec_run  = 1'b0;
    if (opr <= sma_pkg::OP_SWAP) begin
      if (under) begin
        dec_stat = sma_pkg::ST_UNDER;
      end else if (over) begin
        dec_stat = sma_pkg::ST_OVER;
      end else if ((opr == sma_pkg::OP_DIV) && (rd_data == '0)) begin
        dec_stat = sma_pkg::ST_DIV0;
      end else begin
        dec_run = 1'b1;
      end
    end
  end

  // operand selection for the shared adder
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b1;
    case (state)
      S_DECODE: begin
        if (opr == sma_pkg::OP_NEG) begin
          add_y = {xa[DW-1], xa};
        end else begin
          add_x   = {xa[DW-1], xa};
          add_y   = {rd_data[DW-1], rd_data};
          add_sub = (opr != sma_pkg::OP_ADD);
        end
      end
      S_ABSA: add_y = {1'b0, xa};
      S_ABSB: add_y = {1'b0, xb};
      S_DIVS: begin
        add_x = {acc, qr[DW-1]};
        add_y = {1'b0, xb};
      end
      S_FIX: add_y = {1'b0, qr};
      S_MULS: begin
        add_x   = {1'b0, acc[DW-2:0], 1'b0};
        add_y   = qr[DW-1] ? {1'b0, xa} : '0;
        add_sub = 1'b0;
      end
      default: add_sub = 1'b1;
    endcase
  end

  assign sum = {1'b0, add_x} + {1'b0, add_y ^ {(DW+1){add_sub}}} + (DW+2)'(add_sub);
  assign lt  = sum[DW];

  // memory write port: spill of the old top, or second entry on swap
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sp_m1[AW-1:0];
    mem_wdata = top;
    if (state == S_DECODE && !under && !over) begin
      case (opr)
        sma_pkg::OP_CONST: mem_we = (sp != '0);
        sma_pkg::OP_DUP:   mem_we = 1'b1;
        sma_pkg::OP_SWAP: begin
          mem_we    = 1'b1;
          mem_waddr = sp_m2[AW-1:0];
        end
        default: mem_we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sp    <= '0;
      done  <= 1'b0;
      stat  <= sma_pkg::ST_OK;
    end else begin
      case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            opr   <= opcode;
            xval  <= operand_value;
            xa    <= top;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          stat <= dec_stat;
          done <= !(dec_run && ((opr == sma_pkg::OP_MUL) || (opr == sma_pkg::OP_DIV)));
          if (dec_run && (opr == sma_pkg::OP_MUL)) begin
            state <= S_MULS;
          end else if (dec_run && (opr == sma_pkg::OP_DIV)) begin
            state <= S_ABSA;
          end else begin
            state <= S_IDLE;
          end
          if (dec_run) begin
            case (opr)
              sma_pkg::OP_CONST: begin
                top <= xval;
                sp  <= sp + SPW'(1);
              end
              sma_pkg::OP_DUP: sp <= sp + SPW'(1);
              sma_pkg::OP_NEG: top <= sum[DW-1:0];
              sma_pkg::OP_SWAP: top <= rd_data;
              sma_pkg::OP_ADD, sma_pkg::OP_SUB: begin
                top <= sum[DW-1:0];
                sp  <= sp_m1;
              end
              sma_pkg::OP_MAX: begin
                top <= lt ? rd_data : xa;
                sp  <= sp_m1;
              end
              sma_pkg::OP_MIN: begin
                top <= lt ? xa : rd_data;
                sp  <= sp_m1;
              end
              sma_pkg::OP_MUL: begin
                xb  <= rd_data;
                qr  <= rd_data;
                acc <= '0;
                cnt <= '0;
              end
              sma_pkg::OP_DIV: xb <= rd_data;
              default: top <= top;
            endcase
          end
        end
        S_ABSA: begin
          done  <= 1'b0;
          negq  <= xa[DW-1] ^ xb[DW-1];
          xa    <= xa[DW-1] ? sum[DW-1:0] : xa;
          state <= S_ABSB;
        end
        S_ABSB: begin
          done  <= 1'b0;
          xb    <= xb[DW-1] ? sum[DW-1:0] : xb;
          qr    <= xa;
          acc   <= '0;
          cnt   <= '0;
          state <= S_DIVS;
        end
        S_DIVS: begin
          done <= 1'b0;
          acc  <= sum[DW+1] ? sum[DW-1:0] : add_x[DW-1:0];
          qr   <= {qr[DW-2:0], sum[DW+1]};
          cnt  <= cnt + CW'(1);
          if (cnt == CW'(DW-1)) begin
            state <= S_FIX;
          end
        end
        S_FIX: begin
          top   <= negq ? sum[DW-1:0] : qr;
          sp    <= sp_m1;
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_MULS: begin
          acc  <= sum[DW-1:0];
          qr   <= {qr[DW-2:0], 1'b0};
          cnt  <= cnt + CW'(1);
          done <= (cnt == CW'(DW-1));
          if (cnt == CW'(DW-1)) begin
            top   <= sum[DW-1:0];
            sp    <= sp_m1;
            state <= S_IDLE;
          end
        end
        default: begin
          done  <= 1'b0;
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy        = (state != S_IDLE);
  assign top_value   = (sp != '0) ? top : '0;
  assign stack_depth = sp;
  assign status      = stat;

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    sp <= SPW'(STACK_DEPTH))
    else $error("stack pointer beyond depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("request accepted but not busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held");

  a_over_full: assert property (@(posedge clk) disable iff (rst)
    done && status == sma_pkg::ST_OVER |-> sp == SPW'(STACK_DEPTH))
    else $error("overflow reported on a stack that is not full");

  a_under_low: assert property (@(posedge clk) disable iff (rst)
    done && status == sma_pkg::ST_UNDER |-> sp < SPW'(2))
    else $error("underflow reported with two or more entries");

  a_div0_stable: assert property (@(posedge clk) disable iff (rst)
    done && status == sma_pkg::ST_DIV0 |-> sp == $past(sp))
    else $error("depth changed on divide by zero");

endmodule

@@ dv/stack_machine_alu_tb.sv @@
// self-checking testbench for the stack machine alu with a built-in stack predictor
module testbench;

  localparam int OPC_W         = sma_pkg::OPC_W;
  localparam int DATA_W        = sma_pkg::DATA_W;
  localparam int STAT_W        = sma_pkg::STAT_W;
  localparam int STACK_DEPTH_D = sma_pkg::STACK_DEPTH_D;
  localparam int DEPTH_W       = $clog2(STACK_DEPTH_D + 1);
  localparam int RANDOM_ITEMS  = 1700;
  localparam int QUIET_TAIL    = 150;
  localparam int SETTLE        = 60;
  localparam int LIMIT_CYCLES  = 400000;
  localparam logic [OPC_W-1:0] OP_TOP_CODE     = {OPC_W{1'b1}};
  localparam logic [OPC_W-1:0] OP_FIRST_UNUSED = sma_pkg::OP_SWAP + OPC_W'(1);

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_ANY, MIX_FILL} mix_t;

  typedef struct {
    logic [OPC_W-1:0]  op;
    logic [DATA_W-1:0] val;
    bit                drain;
  } instr_t;

  typedef struct {
    logic [DATA_W-1:0]  top;
    logic [DEPTH_W-1:0] depth;
    logic [STAT_W-1:0]  status;
  } stack_view_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic [OPC_W-1:0]          opcode = '0;
  logic signed [DATA_W-1:0]  operand_value = '0;
  logic                      busy;
  logic                      done;
  logic signed [DATA_W-1:0]  top_value;
  logic [DEPTH_W-1:0]        stack_depth;
  logic [STAT_W-1:0]         status;

  instr_t      instr_queue[$];
  stack_view_t stack_views_due[$];
  logic [DATA_W-1:0] shadow_stack [STACK_DEPTH_D];
  int shadow_depth = 0;
  int in_flight = 0;
  int gap_left = 0;
  int errors = 0;
  int cycles = 0;

  stack_machine_alu i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .operand_value(operand_value),
    .done         (done),
    .top_value    (top_value),
    .stack_depth  (stack_depth),
    .status       (status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int operands_needed(input logic [OPC_W-1:0] op);
    if (op == sma_pkg::OP_CONST || op > sma_pkg::OP_SWAP) return 0;
    if (op == sma_pkg::OP_NEG || op == sma_pkg::OP_DUP) return 1;
    return 2;
  endfunction

  function automatic stack_view_t execute_instr(input logic [OPC_W-1:0] op,
                                                input logic [DATA_W-1:0] val);
    logic [DATA_W-1:0] a, b, r, ma, mb, q;
    logic [STAT_W-1:0] st;
    int need;
    stack_view_t v;
    st = sma_pkg::ST_OK;
    a = '0;
    b = '0;
    r = '0;
    need = operands_needed(op);
    if (op <= sma_pkg::OP_SWAP) begin
      if (shadow_depth < need) begin
        st = sma_pkg::ST_UNDER;
      end else if ((op == sma_pkg::OP_CONST || op == sma_pkg::OP_DUP) &&
                   shadow_depth >= STACK_DEPTH_D) begin
        st = sma_pkg::ST_OVER;
      end else begin
        if (need >= 1) a = shadow_stack[shadow_depth-1];
        if (need >= 2) b = shadow_stack[shadow_depth-2];
        case (op)
          sma_pkg::OP_CONST: begin
            shadow_stack[shadow_depth] = val;
            shadow_depth++;
          end
          sma_pkg::OP_DUP: begin
            shadow_stack[shadow_depth] = a;
            shadow_depth++;
          end
          sma_pkg::OP_NEG: shadow_stack[shadow_depth-1] = '0 - a;
          sma_pkg::OP_SWAP: begin
            shadow_stack[shadow_depth-1] = b;
            shadow_stack[shadow_depth-2] = a;
          end
          default: begin
            if (op == sma_pkg::OP_DIV && b == '0) begin
              st = sma_pkg::ST_DIV0;
            end else begin
              case (op)
                sma_pkg::OP_ADD: r = a + b;
                sma_pkg::OP_SUB: r = a - b;
                sma_pkg::OP_MUL: r = a * b;
                sma_pkg::OP_DIV: begin
                  ma = a[DATA_W-1] ? '0 - a : a;
                  mb = b[DATA_W-1] ? '0 - b : b;
                  q  = ma / mb;
                  r  = (a[DATA_W-1] ^ b[DATA_W-1]) ? '0 - q : q;
                end
                sma_pkg::OP_MAX: r = ($signed(a) > $signed(b)) ? a : b;
                default: r = ($signed(a) < $signed(b)) ? a : b;
              endcase
              shadow_stack[shadow_depth-2] = r;
              shadow_depth--;
            end
          end
        endcase
      end
    end
    v.top    = (shadow_depth > 0) ? shadow_stack[shadow_depth-1] : '0;
    v.depth  = shadow_depth[DEPTH_W-1:0];
    v.status = st;
    return v;
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return $urandom_range(0, 1) ? 32'sd1 : -32'sd1;
      2: return 32'h7fff_ffff;
      3: return 32'h8000_0000;
      4: return $urandom_range(0, 32) - 16;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_instr(input logic [OPC_W-1:0] op, input logic [DATA_W-1:0] val,
                           input bit drain = 1'b0);
    instr_t it;
    it.op = op;
    it.val = val;
    it.drain = drain;
    instr_queue.push_back(it);
  endtask

  // driver: holds a request until busy is low, then moves on or idles
  always @(posedge clk) begin : drive
    bit go;
    go = 1'b0;
    if (!rst) begin
      if (done) in_flight--;
      if (start && !busy) begin
        stack_views_due.push_back(execute_instr(opcode, operand_value));
        instr_queue.delete(0);
        in_flight++;
        if (instr_queue.size() > QUIET_TAIL && $urandom_range(0, 3) == 0)
          gap_left = $urandom_range(1, 11);
      end
      if (start && busy) begin
        go = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (instr_queue.size() > 0 && !(instr_queue[0].drain && in_flight > 0)) begin
        go = 1'b1;
        opcode        <= instr_queue[0].op;
        operand_value <= instr_queue[0].val;
      end
    end
    start <= go;
  end

  always @(posedge clk) begin : observe
    stack_view_t want;
    if (!rst && done) begin
      if (stack_views_due.size() == 0) begin
        $display("%0t: unexpected result top %0d depth %0d status %0d", $time,
                 top_value, stack_depth, status);
        errors++;
      end else begin
        want = stack_views_due.pop_front();
        if (top_value !== want.top) begin
          $display("%0t: top_value expected %0d got %0d", $time, $signed(want.top),
                   top_value);
          errors++;
        end
        if (stack_depth !== want.depth) begin
          $display("%0t: stack_depth expected %0d got %0d", $time, want.depth, stack_depth);
          errors++;
        end
        if (status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("%0t: timed out with %0d requests pending", $time, instr_queue.size());
      $display("** stack_machine_alu: FAILED **");
      $finish;
    end
  end

  initial begin
    int made, seg_len, fills, est, pick;
    mix_t mix;
    logic [OPC_W-1:0] op;

    // underflow on the empty stack, unused code on empty
    add_instr(sma_pkg::OP_ADD, '0);
    add_instr(sma_pkg::OP_NEG, '0);
    add_instr(sma_pkg::OP_DUP, '0);
    add_instr(OP_TOP_CODE, 32'hffff_ffff);
    add_instr(sma_pkg::OP_CONST, 32'h7fff_ffff, 1'b1);
    add_instr(sma_pkg::OP_SWAP, '0);
    add_instr(sma_pkg::OP_CONST, 32'sd1);
    add_instr(sma_pkg::OP_ADD, '0);
    add_instr(sma_pkg::OP_CONST, -32'sd1);
    add_instr(sma_pkg::OP_SWAP, '0);
    // most negative over minus one wraps
    add_instr(sma_pkg::OP_DIV, '0);
    add_instr(sma_pkg::OP_NEG, '0);
    add_instr(sma_pkg::OP_CONST, '0);
    add_instr(sma_pkg::OP_SWAP, '0);
    add_instr(sma_pkg::OP_DIV, '0);
    add_instr(sma_pkg::OP_CONST, 32'sd7);
    add_instr(sma_pkg::OP_MUL, '0);
    add_instr(sma_pkg::OP_CONST, 32'sd2);
    add_instr(sma_pkg::OP_CONST, -32'sd7);
    add_instr(sma_pkg::OP_DIV, '0);
    add_instr(sma_pkg::OP_SUB, '0);
    add_instr(sma_pkg::OP_MAX, '0);
    add_instr(sma_pkg::OP_DUP, '0);
    add_instr(sma_pkg::OP_MIN, '0);
    add_instr(OP_FIRST_UNUSED, '0);

    est = 1;
    made = 0;
    fills = 0;
    while (made < RANDOM_ITEMS) begin
      mix = mix_t'($urandom_range(0, 2));
      seg_len = $urandom_range(10, 60);
      if (fills < 2 && made > 400 + fills * 700) begin
        mix = MIX_FILL;
        seg_len = 280;
        fills++;
      end
      for (int k = 0; k < seg_len; k++) begin
        pick = $urandom_range(0, 19);
        case (mix)
          MIX_GROW:   op = (pick < 12) ? sma_pkg::OP_CONST :
                           (pick < 16) ? sma_pkg::OP_DUP :
                           OPC_W'($urandom_range(sma_pkg::OP_ADD, sma_pkg::OP_SWAP));
          MIX_SHRINK: op = (pick < 14) ?
                           OPC_W'($urandom_range(sma_pkg::OP_ADD, sma_pkg::OP_MIN)) :
                           (pick < 16) ?
                           ($urandom_range(0, 1) ? sma_pkg::OP_NEG : sma_pkg::OP_SWAP) :
                           sma_pkg::OP_CONST;
          MIX_FILL:   op = (pick < 5) ? sma_pkg::OP_DUP : sma_pkg::OP_CONST;
          default:    op = (pick == 0) ?
                           OPC_W'($urandom_range(OP_FIRST_UNUSED, OP_TOP_CODE)) :
                           OPC_W'($urandom_range(sma_pkg::OP_CONST, sma_pkg::OP_SWAP));
        endcase
        // keep most sequences well formed
        if (operands_needed(op) > est && $urandom_range(0, 9) != 0) op = sma_pkg::OP_CONST;
        add_instr(op, pick_value(), $urandom_range(0, 199) == 0 || made == 0);
        if (operands_needed(op) <= est) begin
          if ((op == sma_pkg::OP_CONST || op == sma_pkg::OP_DUP) && est < STACK_DEPTH_D)
            est++;
          else if (operands_needed(op) == 2 && op != sma_pkg::OP_SWAP)
            est--;
        end
        made++;
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (instr_queue.size() != 0 || in_flight != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (stack_views_due.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, stack_views_due.size());
      errors++;
    end
    if (errors == 0)
      $display("** stack_machine_alu: PASSED **");
    else
      $display("** stack_machine_alu: FAILED **");
    $finish;
  end

endmodule

@@ stack_machine_alu.f @@
hw/rtl/sma_pkg.sv
hw/rtl/stack_machine_alu.sv
dv/stack_machine_alu_tb.sv
